// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

    // store depth and count width
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int FILL_W  = 5;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_HEAD    = 2'd1,
        ACT_EXACT   = 2'd2,
        ACT_ATLEAST = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } spq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } spq_stat_t;

endpackage

// ----- rtl/spq_controller.sv -----
`timescale 1ns / 1ps

module spq_controller import spq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t state_reg;

    // input ready while idle, or while the update can hand over its beat
    assign s_tready   = (state_reg == S_IDLE) || ((state_reg == S_UPD) && stat.out_free);
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == S_UPD) && stat.out_free;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (cmd.load) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (stat.out_free) begin
                        state_reg <= cmd.load ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/spq_datapath.sv -----
`timescale 1ns / 1ps

module spq_datapath import spq_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  spq_cmd_t                  cmd,
    output spq_stat_t                 stat,
    input  logic [1:0]                in_action,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic [PRIO_W-1:0]         in_prio,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic signed [VALUE_W-1:0] m_out_value,
    output logic [1:0]                m_status,
    output logic [FILL_W-1:0]         m_fill_level
);

    // entry cells, index 0 holds the head
    logic signed [VALUE_W-1:0] vals_reg  [CAPACITY];
    logic [PRIO_W-1:0]         prios_reg [CAPACITY];
    logic [CNT_W-1:0]          count_reg;

    // latched item
    action_t                   action_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [PRIO_W-1:0]         prio_reg;

    // per cell compare flags
    logic [CAPACITY-1:0] ge_next, eq_next, gt_next;
    logic [CAPACITY-1:0] ge_reg, eq_reg, gt_reg;
    logic [CAPACITY-1:0] ge_prev, ge_succ, eq_prev;

    // decision signals
    logic [CAPACITY-1:0]       sel;
    logic [CAPACITY-1:0]       pop_shift;
    logic                      found;
    logic                      full, empty;
    logic                      do_ins, do_pop;
    logic signed [VALUE_W-1:0] removed;
    status_t                   status_next;
    logic [CNT_W-1:0]          count_next;

    // output register
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    status_t                   status_reg;

    assign stat.out_free = !m_valid_reg || m_tready;

    // item latch on an accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= action_t'(in_action);
            value_reg  <= in_value;
            prio_reg   <= in_prio;
        end
    end

    // broadcast compare against every cell
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge_next[i] = (CNT_W'(i) < count_reg) && (prios_reg[i] >= prio_reg);
            eq_next[i] = (CNT_W'(i) < count_reg) && (prios_reg[i] == prio_reg);
            gt_next[i] = prios_reg[i] > prio_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ge_reg <= ge_next;
        eq_reg <= eq_next;
        gt_reg <= gt_next;
    end

    // neighbour views of the flags
    assign ge_prev = {ge_reg[CAPACITY-2:0], 1'b1};
    assign ge_succ = {1'b0, ge_reg[CAPACITY-1:1]};
    assign eq_prev = {eq_reg[CAPACITY-2:0], 1'b0};

    // position select and shift pattern for removal
    always_comb begin
        found     = 1'b0;
        sel       = '0;
        pop_shift = '0;
        case (action_reg)
            ACT_HEAD: begin
                found     = 1'b1;
                sel[0]    = 1'b1;
                pop_shift = '1;
            end
            ACT_EXACT: begin
                found     = |eq_reg;
                sel       = eq_reg & ~eq_prev;
                pop_shift = ~gt_reg;
            end
            ACT_ATLEAST: begin
                found     = ge_reg[0];
                sel       = ge_reg & ~ge_succ;
                pop_shift = ~ge_succ;
            end
            default: begin
                found = 1'b0;
            end
        endcase
    end

    // word at the selected position
    always_comb begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            removed = removed | (sel[i] ? vals_reg[i] : '0);
        end
    end

    // status and count
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign do_ins = (action_reg == ACT_INSERT) && !full;
    assign do_pop = (action_reg != ACT_INSERT) && !empty && found;

    always_comb begin
        if (action_reg == ACT_INSERT) begin
            status_next = full ? ST_FULL : ST_OK;
        end else if (empty) begin
            status_next = ST_EMPTY;
        end else begin
            status_next = found ? ST_OK : ST_NOMATCH;
        end
        if (do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    // cells: open a slot on insert, close the gap on removal
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] lower_val, upper_val;
        logic [PRIO_W-1:0]         lower_prio, upper_prio;

        if (i == 0) begin : g_first
            assign lower_val  = value_reg;
            assign lower_prio = prio_reg;
        end else begin : g_mid
            assign lower_val  = vals_reg[i-1];
            assign lower_prio = prios_reg[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign upper_val  = vals_reg[i];
            assign upper_prio = prios_reg[i];
        end else begin : g_body
            assign upper_val  = vals_reg[i+1];
            assign upper_prio = prios_reg[i+1];
        end

        always_ff @(posedge aclk) begin
            if (cmd.commit) begin
                if (do_ins && !ge_reg[i]) begin
                    vals_reg[i]  <= ge_prev[i] ? value_reg : lower_val;
                    prios_reg[i] <= ge_prev[i] ? prio_reg : lower_prio;
                end else if (do_pop && pop_shift[i]) begin
                    vals_reg[i]  <= upper_val;
                    prios_reg[i] <= upper_prio;
                end
            end
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_value_reg <= do_pop ? removed : -VALUE_W'(1);
            status_reg    <= status_next;
        end
    end

    // fill level is registered with the count it reports
    logic [CNT_W-1:0] fill_reg;

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            fill_reg <= count_next;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_out_value  = out_value_reg;
    assign m_status     = status_reg;
    assign m_fill_level = FILL_W'(fill_reg);

endmodule

// ----- rtl/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Sorted priority queue of CAPACITY data words with 8-bit priorities, held in
// descending priority order, equal priorities oldest first.
// Input channel (s_): one beat per action. s_tuser carries the action
// (insert, pop head, pop exact priority, pop lowest priority at least),
// s_tdata the data word and the priority.
// Result channel (m_): exactly one beat per action with the removed word
// (-1 when nothing is removed), a status code in m_tuser and the fill level.
// Timing: an accepted beat is compared against all cells in parallel in the
// next cycle and the cells shift in the update state, when the result beat is
// registered; the update waits until the result register is free. Actions run
// as the compare state followed by the shift state over the cell row.
// The next input beat is taken in the shift cycle, so a waiting result does
// not hold the input until a second result would have nowhere to go. While
// m_tready stays low with a result pending, the block holds after its compare
// and s_tready drops.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; stored words are not cleared and are never read while empty.
module sorted_priority_queue_unit import spq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_value[31:0], prio[39:32]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_value[31:0], fill_level[36:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    spq_cmd_t  cmd;
    spq_stat_t stat;

    logic signed [VALUE_W-1:0] out_value;
    logic [FILL_W-1:0]         fill_level;

    spq_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_action    (s_tuser),
        .in_value     (s_tdata[31:0]),
        .in_prio      (s_tdata[39:32]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_out_value  (out_value),
        .m_status     (m_tuser),
        .m_fill_level (fill_level)
    );

    // result beat packing
    assign m_tdata = {3'b000, fill_level, out_value};

endmodule

// ----- bench/tb_sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_ITEMS  = 200;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [VALUE_W-1:0] NO_WORD = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] word;
        status_t            status;
        logic [FILL_W-1:0]  fill;
    } pq_result_t;

    typedef struct {
        action_t            act;
        logic [VALUE_W-1:0] word;
        logic [PRIO_W-1:0]  prio;
        int                 rep;
        bit                 typed;
        pq_result_t         want;
    } pq_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // item_value[31:0], prio[39:32]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_value[31:0], fill_level[36:32], zero pad
    logic [1:0]  m_tuser;   // status[1:0]

    // typed expectation travelling beside the beat on offer
    logic        drv_typed;
    pq_result_t  drv_want;

    // own copy of the queue contents
    logic [VALUE_W-1:0] held_word [CAPACITY];
    logic [PRIO_W-1:0]  held_prio [CAPACITY];
    int                 held_count;

    pq_result_t expected_results [$];
    pq_beat_t   directed [$];

    int  errors;
    int  beats_in;
    int  cycles;
    int  status_seen [4];
    int  hold_len;
    bit  quiet;

    sorted_priority_queue_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // applies one action to the held queue and returns the result it gives
    function automatic pq_result_t predict_queue_action(action_t act,
                                                        logic [VALUE_W-1:0] word,
                                                        logic [PRIO_W-1:0] prio);
        pq_result_t r;
        int         pos;
        int         i;
        bit         hit;
        r.word   = NO_WORD;
        r.status = ST_OK;
        pos      = 0;
        hit      = 1'b0;
        if (act == ACT_INSERT) begin
            if (held_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // after every entry of equal or higher priority
                while (pos < held_count && held_prio[pos] >= prio)
                    pos++;
                for (i = held_count; i > pos; i--) begin
                    held_word[i] = held_word[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_word[pos] = word;
                held_prio[pos] = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            case (act)
                ACT_HEAD: begin
                    hit = 1'b1;
                end
                ACT_EXACT: begin
                    // oldest of that priority, scan stops below it
                    for (i = 0; i < held_count && held_prio[i] >= prio; i++) begin
                        if (!hit && held_prio[i] == prio) begin
                            hit = 1'b1;
                            pos = i;
                        end
                    end
                end
                default: begin
                    // last entry still at or above the minimum
                    for (i = 0; i < held_count; i++) begin
                        if (held_prio[i] >= prio) begin
                            hit = 1'b1;
                            pos = i;
                        end
                    end
                end
            endcase
            if (hit) begin
                r.word = held_word[pos];
                for (i = pos; i + 1 < held_count; i++) begin
                    held_word[i] = held_word[i+1];
                    held_prio[i] = held_prio[i+1];
                end
                held_count--;
            end else begin
                r.status = ST_NOMATCH;
            end
        end
        r.fill = FILL_W'(held_count);
        return r;
    endfunction

    function automatic pq_beat_t table_row(action_t act, logic [VALUE_W-1:0] word,
                                           logic [PRIO_W-1:0] prio, int rep, bit typed,
                                           logic [VALUE_W-1:0] want_word,
                                           status_t want_status, int want_fill);
        pq_beat_t b;
        b.act         = act;
        b.word        = word;
        b.prio        = prio;
        b.rep         = rep;
        b.typed       = typed;
        b.want.word   = want_word;
        b.want.status = want_status;
        b.want.fill   = FILL_W'(want_fill);
        return b;
    endfunction

    // offer one beat from a falling edge, hold it until taken
    task automatic send_beat(input pq_beat_t beat);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {beat.prio, beat.word};
        s_tuser   <= beat.act;
        drv_typed <= beat.typed;
        drv_want  <= beat.want;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, expected_results.size());
            $display("tb_sorted_priority_queue_unit: FAIL");
            $finish;
        end
    end

    // result check first, then prediction for the beat taken at this edge
    always @(posedge aclk) begin
        pq_result_t got;
        pq_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.word   = m_tdata[31:0];
                got.status = status_t'(m_tuser);
                got.fill   = m_tdata[36:32];
                status_seen[m_tuser]++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got %h %s %0d",
                             $time, got.word, got.status.name(), got.fill);
                end else begin
                    want = expected_results.pop_front();
                    if (got.word !== want.word) begin
                        errors++;
                        $display("%0t: out_value expected %h, got %h",
                                 $time, want.word, got.word);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %s, got %s",
                                 $time, want.status.name(), got.status.name());
                    end
                    if (got.fill !== want.fill) begin
                        errors++;
                        $display("%0t: fill_level expected %0d, got %0d",
                                 $time, want.fill, got.fill);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_queue_action(action_t'(s_tuser), s_tdata[31:0],
                                            s_tdata[39:32]);
                if (drv_typed)
                    want = drv_want;
                expected_results.push_back(want);
                beats_in++;
            end
        end
    end

    // result side: random hold-off bursts, one long hold to back up the input
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_len == 0 && beats_in >= HOLD_AT) begin
                m_tready <= 1'b0;
                while (hold_len < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_len++;
                end
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // reset, directed table, random actions, drain
    initial begin
        pq_beat_t beat;
        int       r;
        int       k;
        int       n;
        int       insert_pct;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_INSERT;
        drv_typed  = 1'b0;
        drv_want   = '0;
        held_count = 0;
        errors     = 0;
        beats_in   = 0;
        cycles     = 0;
        hold_len   = 0;
        quiet      = 1'b0;
        insert_pct = 50;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // pops on an empty queue
        directed.push_back(table_row(ACT_HEAD,    32'h0, 8'd0,   1, 1, NO_WORD, ST_EMPTY, 0));
        directed.push_back(table_row(ACT_EXACT,   32'h0, 8'd0,   1, 1, NO_WORD, ST_EMPTY, 0));
        directed.push_back(table_row(ACT_ATLEAST, 32'h0, 8'd255, 1, 1, NO_WORD, ST_EMPTY, 0));
        // extreme words and priorities, then a tie
        directed.push_back(table_row(ACT_INSERT, 32'h7FFFFFFF, 8'd255, 1, 1, NO_WORD, ST_OK, 1));
        directed.push_back(table_row(ACT_INSERT, 32'h80000000, 8'd0,   1, 1, NO_WORD, ST_OK, 2));
        directed.push_back(table_row(ACT_INSERT, 32'd5,        8'd100, 1, 0, NO_WORD, ST_OK, 0));
        directed.push_back(table_row(ACT_INSERT, 32'd6,        8'd100, 1, 0, NO_WORD, ST_OK, 0));
        // exact miss, then the pops in turn
        directed.push_back(table_row(ACT_EXACT,   32'h0, 8'd50,  1, 1, NO_WORD, ST_NOMATCH, 4));
        directed.push_back(table_row(ACT_EXACT,   32'h0, 8'd100, 1, 0, NO_WORD, ST_OK, 0));
        directed.push_back(table_row(ACT_HEAD,    32'h0, 8'd0,   1, 0, NO_WORD, ST_OK, 0));
        directed.push_back(table_row(ACT_ATLEAST, 32'h0, 8'd101, 1, 1, NO_WORD, ST_NOMATCH, 2));
        directed.push_back(table_row(ACT_ATLEAST, 32'h0, 8'd0,   1, 0, NO_WORD, ST_OK, 0));
        directed.push_back(table_row(ACT_HEAD,    32'h0, 8'd0,   1, 0, NO_WORD, ST_OK, 0));
        // fill with one priority, insert into a full store
        directed.push_back(table_row(ACT_INSERT, 32'hA5A50000, 8'd9, CAPACITY, 0,
                                     NO_WORD, ST_OK, 0));
        directed.push_back(table_row(ACT_INSERT, 32'hFFFFFFFF, 8'd200, 1, 1,
                                     NO_WORD, ST_FULL, CAPACITY));
        // newest of the lowest, a higher one ahead of an exact match, drain past empty
        directed.push_back(table_row(ACT_ATLEAST, 32'h0, 8'd9, 1, 0, NO_WORD, ST_OK, 0));
        directed.push_back(table_row(ACT_INSERT, 32'h5A5A5A5A, 8'd10, 1, 0, NO_WORD, ST_OK, 0));
        directed.push_back(table_row(ACT_EXACT,  32'h0, 8'd9,  1, 0, NO_WORD, ST_OK, 0));
        directed.push_back(table_row(ACT_HEAD,   32'h0, 8'd0, CAPACITY, 0, NO_WORD, ST_OK, 0));

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        for (r = 0; r < directed.size(); r++) begin
            for (k = 0; k < directed[r].rep; k++) begin
                beat      = directed[r];
                beat.word = directed[r].word + VALUE_W'(k);
                send_beat(beat);
            end
        end

        // random actions in phases that lean towards filling or draining
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            quiet      = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            beat.act   = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT
                                                              : action_t'($urandom_range(1, 3));
            beat.word  = $urandom;
            // narrow priority bands make exact and minimum matches common
            case ($urandom_range(0, 3))
                0:       beat.prio = PRIO_W'($urandom_range(0, 3));
                1:       beat.prio = PRIO_W'($urandom_range(252, 255));
                default: beat.prio = PRIO_W'($urandom);
            endcase
            beat.rep   = 1;
            beat.typed = 1'b0;
            beat.want  = '0;
            send_beat(beat);
        end
        s_tvalid <= 1'b0;

        // wait for the last results
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d actions, results ok/empty/no match/full: %0d/%0d/%0d/%0d",
                 beats_in, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_NOMATCH], status_seen[ST_FULL]);
        $display("one %0d-cycle output hold-off with the input backed up, final fill %0d",
                 hold_len, held_count);
        if (errors == 0)
            $display("tb_sorted_priority_queue_unit: PASS");
        else
            $display("tb_sorted_priority_queue_unit: FAIL");
        $finish;
    end

endmodule
